// ----- src/kpru_pkg.sv -----
// Shared types and constants of the k-permutation rank/unrank block.
`default_nettype none
package kpru_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int RANK_WIDTH_DEF  = 32;
    localparam int CFG_W           = 5;
    localparam int SYM_W           = 8;
    localparam int SLOT_W          = 4;
    localparam int NUM_W           = 32;

    // Register indexes of the configuration port
    localparam logic CFG_SYMBOL_COUNT = 1'b0;
    localparam logic CFG_DIGIT_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_UNRANK = 2'd1,
        ACT_RANK   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [SLOT_W-1:0]   slot;
        logic [SYM_W-1:0]    symbol_in;
        logic [NUM_W-1:0]    number;
        logic                final_symbol;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0]    symbol_out;
        logic [NUM_W-1:0]    rank_out;
        logic                not_found;
        logic                run_end;
    } t_out_word;

    // Queue handshake between front and back
    typedef struct packed {
        logic                valid;
        t_in_word            word;
    } t_cmd;

    // Alphabet after reset: digits then upper-case hex letters
    localparam logic [SYM_W-1:0] RESET_ALPHA [0:15] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

endpackage
`default_nettype wire

// ----- src/kpru_front.sv -----
// Front end: accepts input words, drops ignored actions, queues the rest.
`default_nettype none
module kpru_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire kpru_pkg::t_in_word i_data,
    output kpru_pkg::t_cmd         o_cmd,
    input  wire logic              i_pop
);

    kpru_pkg::t_in_word r_q [0:1];
    logic               r_wr, r_rd;
    logic [1:0]         r_cnt;
    logic               acc, push, pop;

    // Accept whenever a slot is free; classify before queueing
    assign o_stall = (r_cnt == 2'd2);
    assign acc     = i_valid && !o_stall;
    assign push    = acc && (i_data.action != kpru_pkg::ACT_NONE);
    assign pop     = i_pop && (r_cnt != 2'd0);

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.word  = r_q[r_rd];

    // Hold queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Store queued words
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

// ----- src/kpru_back.sv -----
// Back end: alphabet store, bit-serial divider, rank accumulator, output register.
`default_nettype none
module kpru_back #(
    parameter int MAX_SYMBOLS = kpru_pkg::MAX_SYMBOLS_DEF,
    parameter int RANK_WIDTH  = kpru_pkg::RANK_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [kpru_pkg::CFG_W-1:0] i_cfg_data,
    input  wire kpru_pkg::t_cmd            i_cmd,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output kpru_pkg::t_out_word            o_data
);

    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CW = $clog2(RANK_WIDTH);
    localparam int BW = kpru_pkg::CFG_W;
    localparam int SW = kpru_pkg::SYM_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_EMIT, S_RSRCH, S_RADD, S_RFIN
    } t_state;

    t_state                r_st;
    logic [SW-1:0]         r_alpha [0:MAX_SYMBOLS-1];
    logic [SW-1:0]         r_remn  [0:MAX_SYMBOLS-1];
    logic [SW-1:0]         r_work  [0:MAX_SYMBOLS-1];
    logic [BW-1:0]         r_sym_cnt, r_dig_cnt;
    logic [BW-1:0]         r_base, r_cbase, r_left;
    logic [RANK_WIDTH-1:0] r_n, r_weight, r_sum, r_prod_i, r_prod_w;
    logic [BW-1:0]         r_rem;
    logic [CW-1:0]         r_cnt;
    logic                  r_miss, r_in_str, r_last;
    logic [SW-1:0]         r_sym;
    logic                  r_ov;
    kpru_pkg::t_out_word   r_od;

    logic [BW-1:0]         eff_base, eff_len;
    logic [BW:0]           trial;
    logic                  out_free, hit, ov_set;
    logic [IW-1:0]         hit_idx;

    assign o_valid  = r_ov;
    assign o_data   = r_od;
    assign out_free = !r_ov || !i_stall;
    assign o_pop    = (r_st == S_IDLE) && i_cmd.valid;
    assign ov_set   = out_free && ((r_st == S_EMIT) || ((r_st == S_RFIN) && r_last));

    function automatic logic [SW-1:0] RESET_SYM(input int i);
        logic [3:0] k;
        k = i[3:0];
        return kpru_pkg::RESET_ALPHA[k];
    endfunction

    // Clamp the configured counts
    always_comb begin
        if (r_sym_cnt < BW'(2))                eff_base = BW'(2);
        else if (r_sym_cnt > BW'(MAX_SYMBOLS)) eff_base = BW'(MAX_SYMBOLS);
        else                                   eff_base = r_sym_cnt;
        if (r_dig_cnt < BW'(1))        eff_len = BW'(1);
        else if (r_dig_cnt > eff_base) eff_len = eff_base;
        else                           eff_len = r_dig_cnt;
    end

    // One restoring division step
    assign trial = {r_rem, r_n[RANK_WIDTH-1]};

    // Search the remaining alphabet, first match wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((BW'(i) < r_cbase) && (r_remn[i] == r_sym)) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_sym_cnt <= BW'(16);
            r_dig_cnt <= BW'(16);
            r_cbase   <= BW'(MAX_SYMBOLS);
            r_weight  <= RANK_WIDTH'(1);
            r_sum     <= '0;
            r_miss    <= 1'b0;
            r_in_str  <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                r_alpha[i] <= RESET_SYM(i);
                r_remn[i]  <= RESET_SYM(i);
            end
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kpru_pkg::CFG_SYMBOL_COUNT: r_sym_cnt <= i_cfg_data;
                    kpru_pkg::CFG_DIGIT_COUNT:  r_dig_cnt <= i_cfg_data;
                    default: ;
                endcase
            end
            // Drop the output word once taken, unless a new one replaces it
            if (r_ov && !i_stall && !ov_set) r_ov <= 1'b0;

            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        unique case (i_cmd.word.action)
                            kpru_pkg::ACT_LOAD: begin
                                if ({1'b0, i_cmd.word.slot} < 5'(MAX_SYMBOLS))
                                    r_alpha[i_cmd.word.slot[IW-1:0]] <=
                                        i_cmd.word.symbol_in;
                                r_in_str <= 1'b0;
                            end
                            kpru_pkg::ACT_UNRANK: begin
                                for (int i = 0; i < MAX_SYMBOLS; i++)
                                    r_work[i] <= r_alpha[i];
                                r_base <= eff_base;
                                r_left <= eff_len;
                                r_n    <= RANK_WIDTH'(i_cmd.word.number);
                                r_rem  <= '0;
                                r_cnt  <= '0;
                                r_st   <= S_DIV;
                            end
                            kpru_pkg::ACT_RANK: begin
                                if (!r_in_str) begin
                                    for (int i = 0; i < MAX_SYMBOLS; i++)
                                        r_remn[i] <= r_alpha[i];
                                    r_cbase  <= eff_base;
                                    r_weight <= RANK_WIDTH'(1);
                                    r_sum    <= '0;
                                    r_miss   <= 1'b0;
                                    r_in_str <= 1'b1;
                                end
                                r_sym  <= i_cmd.word.symbol_in;
                                r_last <= i_cmd.word.final_symbol;
                                r_st   <= S_RSRCH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    // Shift in one quotient bit per cycle
                    if (trial >= {1'b0, r_base}) begin
                        r_rem <= BW'(trial - {1'b0, r_base});
                        r_n   <= {r_n[RANK_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= BW'(trial);
                        r_n   <= {r_n[RANK_WIDTH-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(RANK_WIDTH - 1)) r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov            <= 1'b1;
                        r_od.symbol_out <= r_work[r_rem[IW-1:0]];
                        r_od.rank_out   <= '0;
                        r_od.not_found  <= 1'b0;
                        r_od.run_end    <= (r_left == BW'(1));
                        for (int i = 0; i < MAX_SYMBOLS - 1; i++)
                            if (IW'(i) >= r_rem[IW-1:0]) r_work[i] <= r_work[i+1];
                        r_base <= r_base - BW'(1);
                        r_left <= r_left - BW'(1);
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        r_st   <= (r_left == BW'(1)) ? S_IDLE : S_DIV;
                    end
                end
                S_RSRCH: begin
                    if (r_miss) begin
                        r_st <= S_RFIN;
                    end else if (hit) begin
                        r_prod_i <= RANK_WIDTH'(RANK_WIDTH'(hit_idx) * r_weight);
                        r_prod_w <= RANK_WIDTH'(r_weight * RANK_WIDTH'(r_cbase));
                        for (int i = 0; i < MAX_SYMBOLS - 1; i++)
                            if (IW'(i) >= hit_idx) r_remn[i] <= r_remn[i+1];
                        r_cbase <= r_cbase - BW'(1);
                        r_st    <= S_RADD;
                    end else begin
                        r_miss <= 1'b1;
                        r_st   <= S_RFIN;
                    end
                end
                S_RADD: begin
                    r_sum    <= r_sum + r_prod_i;
                    r_weight <= r_prod_w;
                    r_st     <= S_RFIN;
                end
                S_RFIN: begin
                    if (!r_last) begin
                        r_st <= S_IDLE;
                    end else if (out_free) begin
                        r_ov            <= 1'b1;
                        r_od.symbol_out <= '0;
                        r_od.rank_out   <= kpru_pkg::NUM_W'(r_sum);
                        r_od.not_found  <= r_miss;
                        r_od.run_end    <= 1'b1;
                        r_in_str        <= 1'b0;
                        r_st            <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/k_permutation_rank_unrank_ordered.sv -----
// Top level of the k-permutation rank/unrank block.
// Maps a number to an ordered k-permutation of a loaded alphabet and back. A front
// queue of two words takes input while the back end works; input stalls only when
// both queue slots are full. The back end dispatches every word from its idle state.
// An unrank word then runs, for every emitted symbol, a bit-serial division step per
// quotient bit and then one emit step. A rank symbol goes through dispatch, search
// and multiply, add and finish when found, and through dispatch, search and finish
// when missing or after a miss; a load needs only its dispatch. Emit and final-symbol
// cycles wait while the output register is still held by the receiver.
`default_nettype none
module k_permutation_rank_unrank_ordered #(
    parameter int MAX_SYMBOLS = kpru_pkg::MAX_SYMBOLS_DEF,
    parameter int RANK_WIDTH  = kpru_pkg::RANK_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire kpru_pkg::t_in_word        i_data,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output kpru_pkg::t_out_word            o_data,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [kpru_pkg::CFG_W-1:0] i_cfg_data
);

    kpru_pkg::t_cmd cmd;
    logic           pop;

    // Accept and queue words
    kpru_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_cmd   (cmd),
        .i_pop   (pop)
    );

    // Execute queued words
    kpru_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .RANK_WIDTH  (RANK_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule
`default_nettype wire
